// ===== rtl/core/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, widths and the azimuth cos/sin table for the pair collision
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

    // fixed-point setup of the scattering math
    localparam int FRAC_BITS       = 16;
    localparam int TRIG_TABLE_SIZE = 1024;
    localparam int TRIG_IDX_W      = $clog2(TRIG_TABLE_SIZE);
    localparam int TRIG_W          = FRAC_BITS + 2;

    // shared multiplier and square root widths
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int RAD_W   = 66;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // configuration register indexes
    localparam logic CFG_CROSS_SECTION = 1'b0;
    localparam logic CFG_INIT_MAX_RATE = 1'b1;

    localparam logic [15:0] CROSS_SECTION_RST = 16'd1000;
    localparam logic [47:0] INIT_MAX_RATE_RST = 48'd1000000000;

    typedef struct packed {
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic signed [31:0] first_vel_z;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic signed [31:0] second_vel_z;
        logic [23:0]        rand_accept;
        logic [23:0]        rand_azimuth;
        logic [23:0]        rand_polar;
        logic               last_in_cell;
    } dpc_in_t;

    typedef struct packed {
        logic signed [31:0] new_first_x;
        logic signed [31:0] new_first_y;
        logic signed [31:0] new_first_z;
        logic signed [31:0] new_second_x;
        logic signed [31:0] new_second_y;
        logic signed [31:0] new_second_z;
        logic               collided;
        logic [47:0]        pair_rate;
    } dpc_out_t;

    // one table entry: {cos, sin}, signed with FRAC_BITS fraction bits
    typedef logic [2*TRIG_W-1:0] trig_rom_t [TRIG_TABLE_SIZE];

    // round a q30 value to FRAC_BITS and clamp at one
    function automatic logic signed [TRIG_W-1:0] q30_to_frac(logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (r > (64'd1 << FRAC_BITS))
        begin
            r = 64'd1 << FRAC_BITS;
        end
        return TRIG_W'(r);
    endfunction

    // cos/sin of every table angle by integer taylor series, built at elaboration
    function automatic trig_rom_t build_trig_rom();
        trig_rom_t          rom;
        logic [63:0]        phase;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        acc;
        logic [63:0]        cq;
        logic [63:0]        sq;
        logic [1:0]         q;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] cphi;
        logic signed [TRIG_W-1:0] sphi;
        for (int k = 0; k < TRIG_TABLE_SIZE; k++)
        begin
            phase = (64'(k) << 32) / TRIG_TABLE_SIZE;
            q     = phase[31:30];
            x     = ((phase & 64'h3FFF_FFFF) * HALF_PI_Q30) >> 30;
            x2    = (x * x) >> 30;
            term  = x;
            acc   = x;
            for (int n = 3; n <= 15; n += 2)
            begin
                term = ((term * x2) >> 30) / 64'((n - 1) * n);
                acc  = (((n >> 1) & 1) != 0) ? acc - term : acc + term;
            end
            sq   = acc[63] ? 64'd0 : acc;
            term = 64'd1 << 30;
            acc  = term;
            for (int n = 2; n <= 14; n += 2)
            begin
                term = ((term * x2) >> 30) / 64'((n - 1) * n);
                acc  = (((n >> 1) & 1) != 0) ? acc - term : acc + term;
            end
            cq = acc[63] ? 64'd0 : acc;
            c  = q30_to_frac(cq);
            s  = q30_to_frac(sq);
            case (q)
                2'd0:
                begin
                    cphi = c;
                    sphi = s;
                end
                2'd1:
                begin
                    cphi = -s;
                    sphi = c;
                end
                2'd2:
                begin
                    cphi = -c;
                    sphi = -s;
                end
                default:
                begin
                    cphi = s;
                    sphi = -c;
                end
            endcase
            rom[k] = {cphi, sphi};
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dpc_isqrt.sv =====
// ----------------------------------------------------------------------------
// dpc_isqrt
// Iterative integer square root, one root bit per cycle (floor of sqrt).
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dpc_pkg::RAD_W-1:0]   radicand,
    output logic                             busy,
    output logic [dpc_pkg::ROOT_W-1:0]       root
);
    import dpc_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // one restoring step: bring in two radicand bits, try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    // iteration counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and root datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dsmc_pair_collision_unit.sv =====
// ----------------------------------------------------------------------------
// dsmc_pair_collision_unit
// Hard-sphere pair collision with acceptance test and isotropic scattering.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one candidate pair per transaction;
//   out_valid/out_ready/out_data return one result per pair, in order.
//   cfg_we/cfg_index/cfg_data write cross_section (0) and initial_max_rate (1);
//   writing initial_max_rate also loads the committed and running maxima.
//   Write configuration only while the unit is idle.
// Operation:
//   one pair at a time; in_ready is high only in the idle state.
//   the result of a rejected pair follows the rate and acceptance steps;
//   an accepted pair goes on to the scattering steps. the bit-serial square
//   root runs once per pair (twice for an accepted pair); the other steps
//   share the single 33x33 multiplier, one step per cycle except while the
//   sequencer waits for the square root to finish.
//   the result register frees the input side: a new pair is taken while the
//   previous result still waits; a stalled receiver holds the next result
//   in its final step until the result register is free.
// Reset:
//   cross_section = 1000, both maxima = 1000000000, cell flag cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmc_pair_collision_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dpc_pkg::dpc_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dpc_pkg::dpc_out_t      out_data,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [47:0]       cfg_data
);
    import dpc_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int CW  = F + 2;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;
    localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * F);
    localparam trig_rom_t TRIG_ROM = build_trig_rom();

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_SQA, ST_VRW, ST_RATE, ST_PHI,
        ST_PLO, ST_DEC, ST_CSQ, ST_SW, ST_TMUL, ST_DXM, ST_DYM, ST_DZM,
        ST_DZS, ST_FIN
    } state_t;

    state_t              state_reg;
    dpc_in_t             in_reg;
    dpc_out_t            out_reg;
    logic                out_valid_reg;
    logic [15:0]         cs_reg;
    logic [47:0]         cmax_reg;
    logic [47:0]         rmax_reg;
    logic                had_reg;
    logic                accept_reg;
    logic [RAD_W-1:0]    acc_reg;
    logic [ROOT_W-1:0]   vr_reg;
    logic [47:0]         rate_reg;
    logic [47:0]         hi_reg;
    logic [F:0]          s_reg;
    logic [ROOT_W-1:0]   t_reg;
    logic [ROOT_W-1:0]   dxm_reg;
    logic [ROOT_W-1:0]   dym_reg;
    logic [ROOT_W-1:0]   dzm_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [2*TRIG_W-1:0] trig_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic                sq_start;
    logic [RAD_W-1:0]    sq_rad;
    logic                sq_busy;
    logic [ROOT_W-1:0]   sq_root;

    logic signed [32:0]  dx;
    logic signed [32:0]  dy;
    logic signed [32:0]  dz;
    logic [31:0]         dx_mag;
    logic [31:0]         dy_mag;
    logic [31:0]         dz_mag;
    logic signed [CW-1:0] c_val;
    logic [F:0]          c_mag;
    logic signed [TRIG_W-1:0] cphi;
    logic signed [TRIG_W-1:0] sphi;
    logic [F:0]          cphi_mag;
    logic [F:0]          sphi_mag;
    logic [TRIG_IDX_W-1:0] trig_idx;
    logic [ROOT_W-1:0]   prod_sh;
    logic [RAD_W-1:0]    sq_sum;
    logic [47:0]         rate_sat;
    logic [71:0]         lhs;
    logic [71:0]         rhs;
    logic                accept_now;
    logic                out_free;
    dpc_out_t            result;

    function automatic logic signed [31:0] sat32(logic signed [35:0] x);
        if (x > 36'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < -36'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // floor((sum + d) / 2) with d = sign ? -mag : mag, saturated
    function automatic logic signed [31:0] half_sat(logic signed [31:0] a,
                                                    logic signed [31:0] b,
                                                    logic               neg,
                                                    logic [ROOT_W-1:0]  mag);
        logic signed [35:0] sum;
        logic signed [35:0] d;
        sum = 36'(a) + 36'(b);
        d   = neg ? -$signed(36'(mag)) : $signed(36'(mag));
        sum = sum + d;
        return sat32(sum >>> 1);
    endfunction

    // relative velocity components and magnitudes
    assign dx     = 33'(in_reg.first_vel_x) - 33'(in_reg.second_vel_x);
    assign dy     = 33'(in_reg.first_vel_y) - 33'(in_reg.second_vel_y);
    assign dz     = 33'(in_reg.first_vel_z) - 33'(in_reg.second_vel_z);
    assign dx_mag = dx[32] ? 32'(-dx) : dx[31:0];
    assign dy_mag = dy[32] ? 32'(-dy) : dy[31:0];
    assign dz_mag = dz[32] ? 32'(-dz) : dz[31:0];

    // polar cosine from the random fraction
    assign c_val = $signed({1'b0, in_reg.rand_polar[23 -: F], 1'b0}) - ONE_C;
    assign c_mag = c_val[CW-1] ? (F+1)'(-c_val) : c_val[F:0];

    // azimuth table lookup, registered read
    assign trig_idx = TRIG_IDX_W'((64'(in_reg.rand_azimuth) * TRIG_TABLE_SIZE) >> 24);
    assign cphi     = trig_reg[2*TRIG_W-1 -: TRIG_W];
    assign sphi     = trig_reg[TRIG_W-1:0];
    assign cphi_mag = cphi[TRIG_W-1] ? (F+1)'(-cphi) : cphi[F:0];
    assign sphi_mag = sphi[TRIG_W-1] ? (F+1)'(-sphi) : sphi[F:0];

    always_ff @(posedge clk)
    begin
        trig_reg <= TRIG_ROM[trig_idx];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = MUL_W'(dx_mag);
                mul_b = MUL_W'(dx_mag);
            end
            ST_SQY:
            begin
                mul_a = MUL_W'(dy_mag);
                mul_b = MUL_W'(dy_mag);
            end
            ST_SQZ:
            begin
                mul_a = MUL_W'(dz_mag);
                mul_b = MUL_W'(dz_mag);
            end
            ST_RATE:
            begin
                mul_a = MUL_W'(cs_reg);
                mul_b = vr_reg;
            end
            ST_PHI:
            begin
                mul_a = MUL_W'(in_reg.rand_accept);
                mul_b = MUL_W'(cmax_reg[47:24]);
            end
            ST_PLO:
            begin
                mul_a = MUL_W'(in_reg.rand_accept);
                mul_b = MUL_W'(cmax_reg[23:0]);
            end
            ST_DEC:
            begin
                mul_a = MUL_W'(c_mag);
                mul_b = MUL_W'(c_mag);
            end
            ST_TMUL:
            begin
                mul_a = vr_reg;
                mul_b = MUL_W'(s_reg);
            end
            ST_DXM:
            begin
                mul_a = vr_reg;
                mul_b = MUL_W'(c_mag);
            end
            ST_DYM:
            begin
                mul_a = t_reg;
                mul_b = MUL_W'(cphi_mag);
            end
            ST_DZM:
            begin
                mul_a = t_reg;
                mul_b = MUL_W'(sphi_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // derived values around the multiplier
    assign prod_sh    = prod_reg[F +: ROOT_W];
    assign sq_sum     = acc_reg + prod_reg;
    assign rate_sat   = (|prod_reg[PROD_W-1:48]) ? {48{1'b1}} : prod_reg[47:0];
    assign lhs        = {rate_reg, 24'd0};
    assign rhs        = {hi_reg, 24'd0} + 72'(prod_reg[47:0]);
    assign accept_now = (lhs > rhs);
    assign out_free   = !out_valid_reg || out_ready;

    // square root unit start and radicand
    assign sq_start = (state_reg == ST_SQA) || (state_reg == ST_CSQ);
    assign sq_rad   = (state_reg == ST_SQA) ? sq_sum : ONE_SQ - prod_reg;

    dpc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // result assembly
    always_comb
    begin
        result           = '0;
        result.collided  = accept_reg;
        result.pair_rate = rate_reg;
        if (accept_reg)
        begin
            result.new_first_x  = half_sat(in_reg.first_vel_x, in_reg.second_vel_x,
                                           c_val[CW-1], dxm_reg);
            result.new_first_y  = half_sat(in_reg.first_vel_y, in_reg.second_vel_y,
                                           cphi[TRIG_W-1], dym_reg);
            result.new_first_z  = half_sat(in_reg.first_vel_z, in_reg.second_vel_z,
                                           sphi[TRIG_W-1], dzm_reg);
            result.new_second_x = half_sat(in_reg.first_vel_x, in_reg.second_vel_x,
                                           !c_val[CW-1], dxm_reg);
            result.new_second_y = half_sat(in_reg.first_vel_y, in_reg.second_vel_y,
                                           !cphi[TRIG_W-1], dym_reg);
            result.new_second_z = half_sat(in_reg.first_vel_z, in_reg.second_vel_z,
                                           !sphi[TRIG_W-1], dzm_reg);
        end
        else
        begin
            result.new_first_x  = in_reg.first_vel_x;
            result.new_first_y  = in_reg.first_vel_y;
            result.new_first_z  = in_reg.first_vel_z;
            result.new_second_x = in_reg.second_vel_x;
            result.new_second_y = in_reg.second_vel_y;
            result.new_second_z = in_reg.second_vel_z;
        end
    end

    // sequencer, configuration and cell state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            cs_reg        <= CROSS_SECTION_RST;
            cmax_reg      <= INIT_MAX_RATE_RST;
            rmax_reg      <= INIT_MAX_RATE_RST;
            had_reg       <= 1'b0;
            accept_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CROSS_SECTION:
                    begin
                        cs_reg <= cfg_data[15:0];
                    end
                    CFG_INIT_MAX_RATE:
                    begin
                        cmax_reg <= cfg_data;
                        rmax_reg <= cfg_data;
                    end
                    default:
                    begin
                        cs_reg <= cs_reg;
                    end
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX:  state_reg <= ST_SQY;
                ST_SQY:  state_reg <= ST_SQZ;
                ST_SQZ:  state_reg <= ST_SQA;
                ST_SQA:  state_reg <= ST_VRW;
                ST_VRW:
                begin
                    if (!sq_busy)
                    begin
                        state_reg <= ST_RATE;
                    end
                end
                ST_RATE: state_reg <= ST_PHI;
                ST_PHI:  state_reg <= ST_PLO;
                ST_PLO:  state_reg <= ST_DEC;
                ST_DEC:
                begin
                    accept_reg <= accept_now;
                    if (rate_reg > rmax_reg)
                    begin
                        rmax_reg <= rate_reg;
                    end
                    state_reg <= accept_now ? ST_CSQ : ST_FIN;
                end
                ST_CSQ:  state_reg <= ST_SW;
                ST_SW:
                begin
                    if (!sq_busy)
                    begin
                        state_reg <= ST_TMUL;
                    end
                end
                ST_TMUL: state_reg <= ST_DXM;
                ST_DXM:  state_reg <= ST_DYM;
                ST_DYM:  state_reg <= ST_DZM;
                ST_DZM:  state_reg <= ST_DZS;
                ST_DZS:  state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg       <= result;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (in_reg.last_in_cell)
                        begin
                            if (had_reg || accept_reg)
                            begin
                                cmax_reg <= rmax_reg;
                            end
                            had_reg <= 1'b0;
                        end
                        else
                        begin
                            had_reg <= had_reg || accept_reg;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        case (state_reg)
            ST_SQY:  acc_reg  <= prod_reg;
            ST_SQZ:  acc_reg  <= acc_reg + prod_reg;
            ST_VRW:  vr_reg   <= sq_root;
            ST_PHI:  rate_reg <= rate_sat;
            ST_PLO:  hi_reg   <= prod_reg[47:0];
            ST_SW:   s_reg    <= sq_root[F:0];
            ST_DXM:  t_reg    <= prod_sh;
            ST_DYM:  dxm_reg  <= prod_sh;
            ST_DZM:  dym_reg  <= prod_sh;
            ST_DZS:  dzm_reg  <= prod_sh;
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dsmc_pair_collision_unit: drives candidate pairs
// with random idle gaps and output stalls, predicts every result in bit-exact
// fixed point and compares each field as results come back in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import dpc_pkg::*;

    localparam int RST_CYCLES    = 12;
    localparam int SETTLE_CYCLES = 120;
    localparam int WATCHDOG_MAX  = 5000;
    localparam logic [47:0] RATE_SAT = 48'hFFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    dpc_in_t     in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    dpc_out_t    out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;

    // predictor copy of configuration and cell state
    logic [15:0] mdl_cross_section;
    logic [47:0] mdl_committed_max;
    logic [47:0] mdl_running_max;
    logic        mdl_cell_hit;

    dpc_out_t    pending_results[$];
    int          error_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles = 0;

    dsmc_pair_collision_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- math
    function automatic logic [34:0] root_wide(logic [67:0] rad);
        logic [69:0] root;
        logic [69:0] cand;
        root = '0;
        for (int b = 34; b >= 0; b--)
        begin
            cand = root | (70'd1 << b);
            if (cand * cand <= {2'b0, rad})
            begin
                root = cand;
            end
        end
        return root[34:0];
    endfunction

    function automatic logic [63:0] root_narrow(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v)
            begin
                root = cand;
            end
        end
        return root;
    endfunction

    function automatic longint round_q30(logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (r > (64'd1 << FRAC_BITS))
        begin
            r = 64'd1 << FRAC_BITS;
        end
        return longint'(r);
    endfunction

    // cos/sin of table entry k by integer series on a quadrant
    task automatic azimuth_trig(input logic [63:0] k, output longint cphi,
                                output longint sphi);
        logic [63:0] phase;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] cq;
        logic [63:0] sq;
        logic [1:0]  q;
        longint      c;
        longint      s;
        phase = (k << 32) / 64'(TRIG_TABLE_SIZE);
        q     = phase[31:30];
        x     = ((phase & 64'h3FFF_FFFF) * HALF_PI_Q30) >> 30;
        x2    = (x * x) >> 30;
        term  = x;
        acc   = x;
        for (int n = 3; n <= 15; n += 2)
        begin
            term = ((term * x2) >> 30) / 64'((n - 1) * n);
            acc  = (((n >> 1) & 1) != 0) ? acc - term : acc + term;
        end
        sq   = acc[63] ? 64'd0 : acc;
        term = 64'd1 << 30;
        acc  = term;
        for (int n = 2; n <= 14; n += 2)
        begin
            term = ((term * x2) >> 30) / 64'((n - 1) * n);
            acc  = (((n >> 1) & 1) != 0) ? acc - term : acc + term;
        end
        cq = acc[63] ? 64'd0 : acc;
        c  = round_q30(cq);
        s  = round_q30(sq);
        case (q)
            2'd0:
            begin
                cphi = c;
                sphi = s;
            end
            2'd1:
            begin
                cphi = -s;
                sphi = c;
            end
            2'd2:
            begin
                cphi = -c;
                sphi = -s;
            end
            default:
            begin
                cphi = s;
                sphi = -c;
            end
        endcase
    endtask

    function automatic longint scale_by_frac(logic [63:0] mag, longint f);
        logic [63:0] af;
        logic [63:0] m;
        af = (f < 0) ? 64'(-f) : 64'(f);
        m  = (mag * af) >> FRAC_BITS;
        return (f < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
        begin
            x = 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            x = -64'sd2147483648;
        end
        return x[31:0];
    endfunction

    // expected result of one pair; advances the predictor's cell state
    task automatic collide_pair(input dpc_in_t p, output dpc_out_t r);
        longint      v1[3];
        longint      v2[3];
        longint      dv[3];
        longint      diff;
        longint      sum;
        longint      cpol;
        longint      cphi;
        longint      sphi;
        logic [67:0] sq_sum;
        logic [63:0] mag;
        logic [63:0] vr;
        logic [63:0] sn;
        logic [63:0] tperp;
        logic [63:0] full_rate;
        logic [47:0] rate;
        logic [95:0] lhs;
        logic [95:0] rhs;
        logic        hit;
        v1[0] = p.first_vel_x;
        v1[1] = p.first_vel_y;
        v1[2] = p.first_vel_z;
        v2[0] = p.second_vel_x;
        v2[1] = p.second_vel_y;
        v2[2] = p.second_vel_z;
        sq_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff   = v1[i] - v2[i];
            mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
            sq_sum = sq_sum + 68'(mag * mag);
        end
        vr        = 64'(root_wide(sq_sum));
        full_rate = 64'(mdl_cross_section) * vr;
        rate      = (full_rate > 64'(RATE_SAT)) ? RATE_SAT : full_rate[47:0];
        // rate / max > rand without division
        lhs = 96'(rate) << 24;
        rhs = 96'(p.rand_accept) * 96'(mdl_committed_max);
        hit = lhs > rhs;
        if (rate > mdl_running_max)
        begin
            mdl_running_max = rate;
        end
        if (hit)
        begin
            cpol  = 2 * longint'(p.rand_polar >> (24 - FRAC_BITS)) - (64'sd1 << FRAC_BITS);
            sn    = root_narrow(64'((64'sd1 << (2 * FRAC_BITS)) - cpol * cpol));
            tperp = (vr * sn) >> FRAC_BITS;
            azimuth_trig((64'(p.rand_azimuth) * TRIG_TABLE_SIZE) >> 24, cphi, sphi);
            dv[0] = scale_by_frac(vr, cpol);
            dv[1] = scale_by_frac(tperp, cphi);
            dv[2] = scale_by_frac(tperp, sphi);
            for (int i = 0; i < 3; i++)
            begin
                sum = v1[i] + v2[i];
                v1[i] = (sum + dv[i]) >>> 1;
                v2[i] = (sum - dv[i]) >>> 1;
            end
            mdl_cell_hit = 1'b1;
        end
        r.new_first_x  = clamp32(v1[0]);
        r.new_first_y  = clamp32(v1[1]);
        r.new_first_z  = clamp32(v1[2]);
        r.new_second_x = clamp32(v2[0]);
        r.new_second_y = clamp32(v2[1]);
        r.new_second_z = clamp32(v2[2]);
        r.collided     = hit;
        r.pair_rate    = rate;
        // commit at cell end only if something collided; flag always clears
        if (p.last_in_cell)
        begin
            if (mdl_cell_hit)
            begin
                mdl_committed_max = mdl_running_max;
            end
            mdl_cell_hit = 1'b0;
        end
    endtask

    // ------------------------------------------------------------ checking
    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // compare each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        dpc_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("new_first_x", 64'(want.new_first_x), 64'(out_data.new_first_x));
                report_field("new_first_y", 64'(want.new_first_y), 64'(out_data.new_first_y));
                report_field("new_first_z", 64'(want.new_first_z), 64'(out_data.new_first_z));
                report_field("new_second_x", 64'(want.new_second_x),
                             64'(out_data.new_second_x));
                report_field("new_second_y", 64'(want.new_second_y),
                             64'(out_data.new_second_y));
                report_field("new_second_z", 64'(want.new_second_z),
                             64'(out_data.new_second_z));
                report_field("collided", 64'(want.collided), 64'(out_data.collided));
                report_field("pair_rate", 64'(want.pair_rate), 64'(out_data.pair_rate));
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------- driving
    task automatic send_pair(dpc_in_t p);
        dpc_out_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        collide_pair(p, r);
        pending_results = {pending_results, r};
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_CROSS_SECTION)
        begin
            mdl_cross_section = value[15:0];
        end
        else
        begin
            mdl_committed_max = value;
            mdl_running_max   = value;
        end
    endtask

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:       return 32'($signed($urandom_range(255)) - 128);
            default: return 32'($signed($urandom_range(2097151)) - 1048576);
        endcase
    endfunction

    function automatic logic [23:0] pick_fraction();
        case ($urandom_range(5))
            0:       return 24'd0;
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic dpc_in_t make_pair(logic [31:0] a, logic [31:0] b, logic [23:0] ra,
                                          logic [23:0] raz, logic [23:0] rp, logic last);
        dpc_in_t p;
        p.first_vel_x  = a;
        p.first_vel_y  = a;
        p.first_vel_z  = a;
        p.second_vel_x = b;
        p.second_vel_y = b;
        p.second_vel_z = b;
        p.rand_accept  = ra;
        p.rand_azimuth = raz;
        p.rand_polar   = rp;
        p.last_in_cell = last;
        return p;
    endfunction

    // --------------------------------------------------------------- tests
    task automatic test_directed();
        // extremes, saturation, zero random and zero rate
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'd0, 24'd0, 1'b0));
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 24'd0, 24'hFF_FFFF,
                            24'hFF_FFFF, 1'b1));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0, 24'h40_0000, 24'h80_0000, 1'b0));
        send_pair(make_pair(32'h0, 32'h0, 24'd0, 24'h80_0000, 24'h80_0000, 1'b1));
        send_pair(make_pair(32'h0001_0000, 32'hFFFF_0000, 24'd1, 24'hC0_0000, 24'h00_0100, 1'b0));
        send_pair(make_pair(32'h0010_0000, 32'h0, 24'h10_0000, 24'h20_0000, 24'h60_0000, 1'b1));
        send_pair(make_pair(32'h7FFF_0000, 32'h8001_0000, 24'h00_0001, 24'h3F_FFFF,
                            24'hFF_FF00, 1'b1));
        // cell end without collision keeps the committed maximum
        send_pair(make_pair(32'h5, 32'h3, 24'hFF_FFFF, 24'd7, 24'd9, 1'b1));
        // zero committed maximum: any nonzero rate passes
        write_reg(CFG_INIT_MAX_RATE, 48'd0);
        send_pair(make_pair(32'h1, 32'h0, 24'hFF_FFFF, 24'h12_3456, 24'hAB_CDEF, 1'b0));
        send_pair(make_pair(32'h9, 32'h9, 24'hFF_FFFF, 24'h12_3456, 24'hAB_CDEF, 1'b1));
        write_reg(CFG_INIT_MAX_RATE, RATE_SAT);
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'd5, 24'd5, 1'b1));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFE, 24'd5, 24'd5, 1'b1));
        // zero cross section never collides
        write_reg(CFG_CROSS_SECTION, 48'd0);
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 24'd0, 24'd0, 24'd0, 1'b1));
        send_pair(make_pair(32'h1234_5678, 32'h0, 24'd0, 24'd3, 24'd3, 1'b0));
        write_reg(CFG_CROSS_SECTION, 48'hFFFF);
        write_reg(CFG_INIT_MAX_RATE, 48'd1000000000);
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 24'h80_0000, 24'h55_5555,
                            24'h33_3333, 1'b1));
        send_pair(make_pair(32'h0000_1000, 32'h0, 24'h00_0010, 24'hAA_AAAA, 24'hCC_CCCC, 1'b1));
        drain_results();
    endtask

    task automatic test_random_pairs(int count, int idle_pct, int stall_pct,
                                     logic [15:0] cs, logic [47:0] max_rate);
        dpc_in_t p;
        write_reg(CFG_CROSS_SECTION, 48'(cs));
        write_reg(CFG_INIT_MAX_RATE, max_rate);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            p.first_vel_x  = pick_velocity();
            p.first_vel_y  = pick_velocity();
            p.first_vel_z  = pick_velocity();
            p.second_vel_x = pick_velocity();
            p.second_vel_y = pick_velocity();
            p.second_vel_z = pick_velocity();
            p.rand_accept  = pick_fraction();
            p.rand_azimuth = pick_fraction();
            p.rand_polar   = pick_fraction();
            p.last_in_cell = ($urandom_range(7) == 0);
            send_pair(p);
            // hold off the sender until the unit is fully drained
            if (n == count / 2)
            begin
                drain_results();
            end
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------- main
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_CROSS_SECTION;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mdl_cross_section = CROSS_SECTION_RST;
        mdl_committed_max = INIT_MAX_RATE_RST;
        mdl_running_max   = INIT_MAX_RATE_RST;
        mdl_cell_hit      = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_pairs(400, 0, 0, 16'd1000, 48'd1000000000);
        test_random_pairs(400, 50, 0, 16'hFFFF, 48'd0);
        test_random_pairs(400, 0, 50, 16'd1, RATE_SAT);
        test_random_pairs(400, 7, 7, 16'($urandom_range(65535, 1)), 48'($urandom));
        drain_results();

        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
